>>> rtl/core/sm4be_pkg.sv
package sm4be_pkg;

	localparam int ROUNDS    = 32;
	localparam int RIDX_W    = $clog2(ROUNDS);
	localparam int BLOCK_W   = 128;
	localparam int WORD_W    = 32;
	localparam int IN_DATA_W = 168;
	localparam int OUT_DATA_W = 128;

	// request kinds carried on s_tuser
	localparam logic REQ_KEY_WRITE = 1'b0;
	localparam logic REQ_ENCRYPT   = 1'b1;

	// one pipeline slot: key-write requests ride the chain with the blocks
	typedef struct packed {
		logic                is_key;
		logic [RIDX_W-1:0]   key_index;
		logic                last;
		logic [BLOCK_W-1:0]  data;   // {X0,X1,X2,X3} window, or key word in [31:0]
	} item_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [WORD_W-1:0] subst_word(input logic [WORD_W-1:0] a);
		return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
	endfunction

	function automatic logic [WORD_W-1:0] mix_linear(input logic [WORD_W-1:0] b);
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
			^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
	endfunction

endpackage

>>> rtl/core/sm4be_round_cell.sv
module sm4be_round_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [sm4be_pkg::RIDX_W-1:0] cell_idx,
	input  logic                        in_valid,
	input  sm4be_pkg::item_t            in_item,
	output logic                        out_valid,
	output sm4be_pkg::item_t            out_item
);
	import sm4be_pkg::*;

	logic [WORD_W-1:0] rk_q;
	logic              valid_s1;
	item_t             item_s1;
	logic              key_hit;
	logic [WORD_W-1:0] x0, x1, x2, x3, t, nx;
	item_t             next_item;

	// latch own round key as the key-write request passes by
	assign key_hit = en & in_valid & in_item.is_key & (in_item.key_index == cell_idx);

	always_ff @(posedge clk) begin
		if (key_hit) begin
			rk_q <= in_item.data[WORD_W-1:0];
		end
	end

	assign x0 = in_item.data[127:96];
	assign x1 = in_item.data[95:64];
	assign x2 = in_item.data[63:32];
	assign x3 = in_item.data[31:0];
	assign t  = x1 ^ x2 ^ x3 ^ rk_q;
	assign nx = x0 ^ mix_linear(subst_word(t));

	always_comb begin
		next_item = in_item;
		if (!in_item.is_key) begin
			next_item.data = {x1, x2, x3, nx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= next_item;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

>>> rtl/core/sm4_block_encrypt_unit.sv
// Channel   | Dir | Fields (low bit first)
// ----------+-----+---------------------------------------------------------------
// s_*       | in  | tdata: key_index[4:0], key_word[36:5], block_hi[100:37],
//           |     |        block_lo[164:101], zero pad; tuser: req_type; tlast: final_block
// m_*       | out | tdata: cipher_hi[63:0], cipher_lo[127:64]; tlast: last_of_batch
//
// One request per cycle when m_tready stays high; a ciphertext passes through the chain
// of 32 round cells and then the output register before it leaves.
// Key writes travel down the same chain; the cell whose index matches key_index takes
// the key word, so every block uses the keys written before it. Key writes give no output.
// Reset clears only valid flags; round keys hold garbage until written.
// A stalled output freezes the whole chain and drops s_tready.
module sm4_block_encrypt_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sm4be_pkg::IN_DATA_W-1:0]     s_tdata,  // key_index, key_word, block_hi, block_lo
	input  logic                                s_tuser,  // req_type
	input  logic                                s_tlast,  // final_block
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sm4be_pkg::OUT_DATA_W-1:0]    m_tdata,  // cipher_hi, cipher_lo
	output logic                                m_tlast   // last_of_batch
);
	import sm4be_pkg::*;

	logic              en;
	logic              in_valid;
	item_t             in_item;
	logic              valid_c [ROUNDS+1];
	item_t             item_c  [ROUNDS+1];
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic              out_last_q;
	item_t             tail;

	// advance the chain whenever the output slot is free or being drained
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign in_valid = s_tvalid;

	// unpack the request into a chain slot
	always_comb begin
		in_item.is_key    = (s_tuser == REQ_KEY_WRITE);
		in_item.key_index = s_tdata[4:0];
		in_item.last      = s_tlast;
		if (s_tuser == REQ_KEY_WRITE) begin
			in_item.data = {96'd0, s_tdata[36:5]};
		end else begin
			in_item.data = {s_tdata[100:37], s_tdata[164:101]};
		end
	end

	assign valid_c[0] = in_valid;
	assign item_c[0]  = in_item;

	for (genvar i = 0; i < ROUNDS; i++) begin : g_round
		sm4be_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.cell_idx  (RIDX_W'(i)),
			.in_valid  (valid_c[i]),
			.in_item   (item_c[i]),
			.out_valid (valid_c[i+1]),
			.out_item  (item_c[i+1])
		);
	end

	assign tail = item_c[ROUNDS];

	// hold the ciphertext until taken; drop key-write requests here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_c[ROUNDS] & ~tail.is_key;
		end
	end

	// window is {X32,X33,X34,X35}; emit in reversed word order
	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {tail.data[95:64], tail.data[127:96],
				tail.data[31:0], tail.data[63:32]};
			out_last_q <= tail.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

>>> sim/tb_sm4_block_encrypt_unit.sv
`timescale 1ns / 100ps

module tb_sm4_block_encrypt_unit;

	// one request as the sender sees it, before packing onto the stream
	typedef struct {
		bit        req_type;
		bit [4:0]  key_index;
		bit [31:0] key_word;
		bit [63:0] block_hi;
		bit [63:0] block_lo;
		bit        final_block;
	} sm4_req_t;

	// one ciphertext as it should leave the block
	typedef struct {
		bit [63:0] cipher_hi;
		bit [63:0] cipher_lo;
		bit        last_of_batch;
	} cipher_t;

	// receiver ready patterns, switched at random
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

	localparam int RANDOM_REQS   = 2000;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int REPORT_MAX    = 10;

	localparam bit [7:0] SBOX_TABLE [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,
		8'h28,8'hfb,8'h2c,8'h05,8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
		8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,8'h9c,8'h42,8'h50,8'hf4,
		8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,
		8'h75,8'h8f,8'h3f,8'ha6,8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
		8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,8'h68,8'h6b,8'h81,8'hb2,
		8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,
		8'h01,8'h21,8'h78,8'h87,8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
		8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,8'hea,8'hbf,8'h8a,8'hd2,
		8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,
		8'hf5,8'h8c,8'hb1,8'he3,8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
		8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,8'hd5,8'hdb,8'h37,8'h45,
		8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,
		8'h1f,8'h10,8'h5a,8'hd8,8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
		8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,8'h89,8'h69,8'h97,8'h4a,
		8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,
		8'hd7,8'hcb,8'h39,8'h48
	};

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [sm4be_pkg::IN_DATA_W-1:0]   s_tdata = '0;   // key_index, key_word, block_hi, block_lo
	logic                              s_tuser = 1'b0; // req_type
	logic                              s_tlast = 1'b0; // final_block
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [sm4be_pkg::OUT_DATA_W-1:0]  m_tdata;        // cipher_hi, cipher_lo
	logic                              m_tlast;        // last_of_batch

	// requests not yet accepted; request_q[0] is the one on the bus
	sm4_req_t    request_q[$];
	// ciphertexts predicted at acceptance, oldest first
	cipher_t     cipher_expect_q[$];
	// round keys as the block should hold them after every accepted request
	bit [31:0]   rk_model [32];

	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned rx_left = 0;
	rx_pattern_t rx_pattern = RX_OPEN;

	sm4_block_encrypt_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit [31:0] rotl(bit [31:0] v, int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// byte-wise S-box, then the linear diffusion step
	function automatic bit [31:0] round_mix(bit [31:0] a);
		bit [31:0] b;
		b = {SBOX_TABLE[a[31:24]], SBOX_TABLE[a[23:16]],
			SBOX_TABLE[a[15:8]], SBOX_TABLE[a[7:0]]};
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	// 32 rounds over the current key set; output is the last four words reversed
	function automatic cipher_t encrypt_block(sm4_req_t r);
		bit [31:0] w0, w1, w2, w3, nx;
		cipher_t   c;
		{w0, w1} = r.block_hi;
		{w2, w3} = r.block_lo;
		for (int i = 0; i < 32; i++) begin
			nx = w0 ^ round_mix(w1 ^ w2 ^ w3 ^ rk_model[i]);
			w0 = w1;
			w1 = w2;
			w2 = w3;
			w3 = nx;
		end
		c.cipher_hi = {w3, w2};
		c.cipher_lo = {w1, w0};
		c.last_of_batch = r.final_block;
		return c;
	endfunction

	// ignored fields get random content so the block is shown not to use them
	function automatic sm4_req_t key_write(bit [4:0] idx, bit [31:0] word);
		sm4_req_t r;
		r.req_type = sm4be_pkg::REQ_KEY_WRITE;
		r.key_index = idx;
		r.key_word = word;
		r.block_hi = rand64();
		r.block_lo = rand64();
		r.final_block = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic sm4_req_t encrypt_req(bit [63:0] hi, bit [63:0] lo, bit fin);
		sm4_req_t r;
		r.req_type = sm4be_pkg::REQ_ENCRYPT;
		r.key_index = 5'($urandom_range(0, 31));
		r.key_word = $urandom;
		r.block_hi = hi;
		r.block_lo = lo;
		r.final_block = fin;
		return r;
	endfunction

	// update the key set, or predict the ciphertext, in acceptance order
	function automatic void accept_request(sm4_req_t r);
		if (r.req_type == sm4be_pkg::REQ_KEY_WRITE)
			rk_model[r.key_index] = r.key_word;
		else
			cipher_expect_q.push_back(encrypt_block(r));
	endfunction

	function automatic void note_mismatch(string what, cipher_t want, cipher_t got);
		error_count++;
		if (error_count <= REPORT_MAX)
			$display("mismatch (%s): expected hi=%h lo=%h last=%0b, got hi=%h lo=%h last=%0b",
				what, want.cipher_hi, want.cipher_lo, want.last_of_batch,
				got.cipher_hi, got.cipher_lo, got.last_of_batch);
	endfunction

	// Stimulus: load every round key before the first encryption so that no
	// block ever reads a key that was never written, then run the directed
	// blocks, then the random mix.
	initial begin
		int unsigned n;
		int unsigned pick;
		bit          fresh_up;

		request_q.push_back(key_write(5'd0, 32'h0000_0000));
		for (int i = 1; i < 31; i++)
			request_q.push_back(key_write(i[4:0], $urandom));
		request_q.push_back(key_write(5'd31, 32'hffff_ffff));

		// extremes of the block, both batch marks
		request_q.push_back(encrypt_req(64'h0, 64'h0, 1'b0));
		request_q.push_back(encrypt_req('1, '1, 1'b1));
		request_q.push_back(encrypt_req(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0));
		request_q.push_back(encrypt_req(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1));
		request_q.push_back(encrypt_req(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 1'b0));
		// key updates right between blocks: the next block must see the new key
		request_q.push_back(key_write(5'd0, 32'hffff_ffff));
		request_q.push_back(encrypt_req(64'h0, 64'h0, 1'b1));
		request_q.push_back(key_write(5'd31, 32'h0000_0000));
		request_q.push_back(encrypt_req('1, '1, 1'b0));
		request_q.push_back(key_write(5'd17, 32'h8000_0001));
		request_q.push_back(encrypt_req(rand64(), rand64(), 1'b1));

		// mostly blocks, with stray key updates and now and then a full reload
		n = 0;
		while (n < RANDOM_REQS) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				fresh_up = 1'($urandom_range(0, 1));
				for (int i = 0; i < 32; i++)
					request_q.push_back(key_write(fresh_up ? i[4:0] : 5'(31 - i), $urandom));
				n += 32;
			end else if (pick < 15) begin
				request_q.push_back(key_write(5'($urandom_range(0, 31)), $urandom));
				n++;
			end else begin
				request_q.push_back(encrypt_req(rand64(), rand64(),
					$urandom_range(0, 3) == 0));
				n++;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the sender to run dry, then for the last ciphertext
		while (request_q.size() != 0 || s_tvalid)
			@(negedge clk);
		while (cipher_expect_q.size() != 0)
			@(negedge clk);
		// catch anything extra coming down the round chain
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0 && cipher_expect_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Sender: hold a request until accepted, send in bursts of random length
	// with random gaps; some bursts are followed by no gap at all.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				accept_request(request_q[0]);
				void'(request_q.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				// hold the current request
			end else if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (request_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {3'b000, request_q[0].block_lo, request_q[0].block_hi,
					request_q[0].key_word, request_q[0].key_index};
				s_tuser  <= request_q[0].req_type;
				s_tlast  <= request_q[0].final_block;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 64);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(20, 40);
						default: gap_left = $urandom_range(1, 6);
					endcase
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: switch between always ready, coin flips, sparse ready and
	// mostly ready, each held for a random stretch.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_left == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 256);
			end else begin
				rx_left--;
			end
			case (rx_pattern)
				RX_OPEN: begin
					m_tready <= 1'b1;
				end
				RX_COIN: begin
					m_tready <= 1'($urandom_range(0, 1));
				end
				RX_SPARSE: begin
					m_tready <= (rx_left % 8) == 0;
				end
				default: begin
					m_tready <= $urandom_range(0, 9) != 0;
				end
			endcase
		end
	end

	// Checker: compare each accepted ciphertext with the oldest prediction.
	always @(posedge clk) begin
		cipher_t got;
		cipher_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.cipher_hi = m_tdata[63:0];
			got.cipher_lo = m_tdata[127:64];
			got.last_of_batch = m_tlast;
			if (cipher_expect_q.size() == 0) begin
				want = '{default: '0};
				note_mismatch("unexpected output", want, got);
			end else begin
				want = cipher_expect_q.pop_front();
				if (got.cipher_hi != want.cipher_hi)
					note_mismatch("cipher_hi", want, got);
				else if (got.cipher_lo != want.cipher_lo)
					note_mismatch("cipher_lo", want, got);
				else if (got.last_of_batch != want.last_of_batch)
					note_mismatch("last_of_batch", want, got);
			end
		end
	end

	// Watchdog: end the run when neither side has moved a request for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
